/* hdl/arshs_pkg.sv */
package arshs_pkg;

  localparam int BlockBytes = 16;
  localparam int QueueDepth = 2;
  localparam int FinSteps   = 12;

  // lane bytes in memory order, byte j at bits 8j+7:8j
  localparam logic [511:0] PI_LANES = {
    64'h1709_47b5_b5d5_843f,
    64'hdd50_7cc9_b729_acc0,
    64'h6c0c_e934_cf66_54be,
    64'h7713_d038_e621_2845,
    64'h896c_4eec_98fa_2e08,
    64'hd031_9f29_2238_09a4,
    64'h4473_7003_2e8a_1913,
    64'hd308_a385_886a_3f24
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  typedef struct packed {
    logic [127:0] blk;
    logic [63:0]  cnt;
    logic         absorb;
    logic         final_job;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FIN,
    BK_OUT
  } back_state_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k);
    logic [7:0]   t [16];
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[j + 4 * c] = SBOX[s[8 * (j + 4 * ((c + j) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      r[8 * (4 * c) +: 8]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3 ^ k[8 * (4 * c) +: 8];
      r[8 * (4 * c + 1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3
                                ^ k[8 * (4 * c + 1) +: 8];
      r[8 * (4 * c + 2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3
                                ^ k[8 * (4 * c + 2) +: 8];
      r[8 * (4 * c + 3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)
                                ^ k[8 * (4 * c + 3) +: 8];
    end
    aes_round = r;
  endfunction

  function automatic logic [511:0] absorb(input logic [511:0] lanes, input logic [127:0] blk);
    logic [511:0] r;
    for (int l = 0; l < 4; l++) begin
      r[128 * l +: 128] = aes_round(lanes[128 * l +: 128] ^ blk, PI_LANES[128 * l +: 128]);
    end
    absorb = r;
  endfunction

endpackage

/* hdl/arshs_front.sv */
module arshs_front
  import arshs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       message_end,
  output logic       push,
  output job_t       push_job,
  input  logic       queue_full
);

  logic [127:0] buffer;
  logic [3:0]   count;
  logic [63:0]  counter;

  logic         accept;
  logic [4:0]   count_new;
  logic [63:0]  counter_new;
  logic [127:0] merged;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    count_new   = {1'b0, count} + {4'd0, byte_valid};
    counter_new = counter + (byte_valid ? 64'd8 : 64'd0);
    merged      = buffer;
    if (byte_valid) begin
      merged[8 * count +: 8] = data_byte;
    end
    // zero pad bytes past the fill level
    for (int i = 0; i < BlockBytes; i++) begin
      if (5'(i) >= count_new) begin
        merged[8 * i +: 8] = 8'h00;
      end
    end
    push                = accept && (count_new[4] || message_end);
    push_job.blk        = merged;
    push_job.cnt        = counter_new;
    push_job.absorb     = count_new != 5'd0;
    push_job.final_job  = message_end;
  end

  always_ff @(posedge clk) begin
    if (accept && byte_valid) begin
      buffer <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      counter <= '0;
    end else if (accept) begin
      count   <= push ? 4'd0 : count_new[3:0];
      counter <= message_end ? 64'd0 : counter_new;
    end
  end

endmodule

/* hdl/arshs_queue.sv */
module arshs_queue
  import arshs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t       mem [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;

  assign full      = used == 2'(QueueDepth);
  assign pop_valid = used != 2'd0;
  assign pop_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      used <= used + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hdl/arshs_back.sv */
module arshs_back
  import arshs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        pop,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  back_state_t  state, state_next;
  logic [511:0] lanes, lanes_next;
  logic [511:0] saved, saved_next;
  logic [3:0]   step, step_next;
  logic [2:0]   widx, widx_next;
  logic         load;
  logic [511:0] lanes_in;
  logic [511:0] lanes_abs;
  logic [127:0] fin_blk;

  always_comb begin
    lanes_in             = lanes;
    lanes_in[447:384]    = lanes[447:384] ^ job.cnt;
    lanes_in[511:448]    = lanes[511:448] ^ job.cnt;
    fin_blk              = saved[128 * step[1:0] +: 128];
    lanes_abs            = absorb(state == BK_FIN ? lanes : lanes_in,
                                  state == BK_FIN ? fin_blk : job.blk);
  end

  always_comb begin
    state_next = state;
    lanes_next = lanes;
    saved_next = saved;
    step_next  = step;
    widx_next  = widx;
    pop        = 1'b0;
    load       = 1'b0;
    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          pop = 1'b1;
          if (job.final_job) begin
            saved_next = job.absorb ? lanes_abs : lanes;
            lanes_next = PI_LANES;
            step_next  = '0;
            state_next = BK_FIN;
          end else if (job.absorb) begin
            lanes_next = lanes_abs;
          end
        end
      end
      BK_FIN: begin
        lanes_next = lanes_abs;
        step_next  = step + 4'd1;
        if (step == 4'(FinSteps - 1)) begin
          widx_next  = '0;
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid || out_ready) begin
          load      = 1'b1;
          widx_next = widx + 3'd1;
          if (widx == 3'd7) begin
            lanes_next = PI_LANES;
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      lanes     <= PI_LANES;
      step      <= '0;
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      lanes <= lanes_next;
      step  <= step_next;
      widx  <= widx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    saved <= saved_next;
    if (load) begin
      digest_word <= lanes[64 * widx +: 64] ^ saved[64 * widx[0] +: 64];
      word_index  <= widx;
      last_word   <= widx == 3'd7;
    end
  end

endmodule

/* hdl/aes_round_stream_hash_512.sv */
// channel  | handshake            | payload
// input    | in_valid / in_ready  | data_byte, byte_valid, message_end
// output   | out_valid / out_ready| digest_word, word_index, last_word
//
// one byte is taken per cycle while the job queue is not full; the back end absorbs
// a full block with four parallel aes rounds, so bytes stream at one per cycle.
// message end absorbs the last block, then twelve rounds, then eight transfers.
// a two-entry job queue lets the front keep taking bytes during finalization.
// rst is synchronous; lanes return to the pi constants.
module aes_round_stream_hash_512
  import arshs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  logic push, full, job_valid, pop;
  job_t push_job, pop_job;

  arshs_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .byte_valid(byte_valid), .message_end(message_end),
    .push(push), .push_job(push_job), .queue_full(full)
  );

  arshs_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .full(full),
    .pop_valid(job_valid), .pop(pop), .pop_job(pop_job)
  );

  arshs_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .pop(pop), .job(pop_job),
    .out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

endmodule

/* tb/tb_aes_round_stream_hash_512.sv */
`timescale 1ns / 100ps

module tb_aes_round_stream_hash_512;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 400;

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       is_end;
  } msg_item_t;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  aes_round_stream_hash_512 DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .byte_valid(byte_valid), .message_end(message_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  msg_item_t    pending_items[$];
  digest_item_t expected_words[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           error_count = 0;
  int           cycles = 0;

  // hash model state, lanes kept as bytes in memory order
  logic [7:0]  sbox_tbl [256];
  logic [7:0]  pi_tbl [64];
  logic [7:0]  lane_bytes [64];
  logic [7:0]  blk_bytes [16];
  int          blk_fill;
  logic [63:0] length_bits;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] b, input int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  task automatic build_tables();
    logic [7:0] r, base;
    int e;
    for (int x = 0; x < 256; x++) begin
      r = 8'd1;
      base = x[7:0];
      e = 254;
      while (e != 0) begin
        if (e & 1) r = gmul(r, base);
        base = gmul(base, base);
        e = e >> 1;
      end
      sbox_tbl[x] = r ^ rot8(r, 1) ^ rot8(r, 2) ^ rot8(r, 3) ^ rot8(r, 4) ^ 8'h63;
    end
    pi_tbl = '{8'h24, 8'h3F, 8'h6A, 8'h88, 8'h85, 8'hA3, 8'h08, 8'hD3,
               8'h13, 8'h19, 8'h8A, 8'h2E, 8'h03, 8'h70, 8'h73, 8'h44,
               8'hA4, 8'h09, 8'h38, 8'h22, 8'h29, 8'h9F, 8'h31, 8'hD0,
               8'h08, 8'h2E, 8'hFA, 8'h98, 8'hEC, 8'h4E, 8'h6C, 8'h89,
               8'h45, 8'h28, 8'h21, 8'hE6, 8'h38, 8'hD0, 8'h13, 8'h77,
               8'hBE, 8'h54, 8'h66, 8'hCF, 8'h34, 8'hE9, 8'h0C, 8'h6C,
               8'hC0, 8'hAC, 8'h29, 8'hB7, 8'hC9, 8'h7C, 8'h50, 8'hDD,
               8'h3F, 8'h84, 8'hD5, 8'hB5, 8'hB5, 8'h47, 8'h09, 8'h17};
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 64; i++) lane_bytes[i] = pi_tbl[i];
    for (int i = 0; i < 16; i++) blk_bytes[i] = '0;
    blk_fill = 0;
    length_bits = '0;
  endtask

  // every lane takes the block and one keyed round
  task automatic mix_block(input logic [7:0] blk [16]);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    int o;
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < 16; i++) s[i] = lane_bytes[16 * l + i] ^ blk[i];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r + 4 * c] = sbox_tbl[s[r + 4 * ((c + r) % 4)]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        o = 16 * l + 4 * c;
        lane_bytes[o]     = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3 ^ pi_tbl[o];
        lane_bytes[o + 1] = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3 ^ pi_tbl[o + 1];
        lane_bytes[o + 2] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3) ^ pi_tbl[o + 2];
        lane_bytes[o + 3] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2) ^ pi_tbl[o + 3];
      end
    end
  endtask

  task automatic mix_with_length();
    for (int i = 0; i < 8; i++) begin
      lane_bytes[48 + i] ^= length_bits[8 * i +: 8];
      lane_bytes[56 + i] ^= length_bits[8 * i +: 8];
    end
    mix_block(blk_bytes);
  endtask

  task automatic predict_digest(input msg_item_t it);
    logic [7:0] saved [4][16];
    logic [7:0] one [16];
    digest_item_t d;
    if (it.has_byte) begin
      blk_bytes[blk_fill] = it.data;
      blk_fill++;
      length_bits += 8;
      if (blk_fill == 16) begin
        mix_with_length();
        blk_fill = 0;
      end
    end
    if (it.is_end) begin
      if (blk_fill != 0) begin
        for (int i = blk_fill; i < 16; i++) blk_bytes[i] = '0;
        mix_with_length();
      end
      for (int l = 0; l < 4; l++)
        for (int i = 0; i < 16; i++) saved[l][i] = lane_bytes[16 * l + i];
      for (int i = 0; i < 64; i++) lane_bytes[i] = pi_tbl[i];
      for (int r = 0; r < 3; r++)
        for (int l = 0; l < 4; l++) begin
          one = saved[l];
          mix_block(one);
        end
      for (int k = 0; k < 8; k++) begin
        for (int i = 0; i < 8; i++)
          d.word[8 * i +: 8] = lane_bytes[8 * k + i] ^ saved[0][8 * (k % 2) + i];
        d.index = k[2:0];
        d.last = (k == 7);
        expected_words.push_back(d);
      end
      restart_hash();
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_digest('{data: data_byte, has_byte: byte_valid, is_end: message_end});
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          msg_item_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          data_byte <= it.data;
          byte_valid <= it.has_byte;
          message_end <= it.is_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("digest word with nothing expected: %h", digest_word);
          error_count++;
        end else begin
          digest_item_t d;
          d = expected_words.pop_front();
          if (digest_word !== d.word) begin
            $error("digest_word expected %h actual %h", d.word, digest_word);
            error_count++;
          end
          if (word_index !== d.index) begin
            $error("word_index expected %0d actual %0d", d.index, word_index);
            error_count++;
          end
          if (last_word !== d.last) begin
            $error("last_word expected %0d actual %0d", d.last, last_word);
            error_count++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HoldCycles;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_aes_round_stream_hash_512: done, errors");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic bv, input logic me);
    pending_items.push_back('{data: b, has_byte: bv, is_end: me});
  endtask

  // message of len bytes; end rides on the last byte or comes alone
  task automatic push_message(input int len, input bit noisy);
    bit end_alone;
    end_alone = (len == 0) || ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(9) == 0) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
      push_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !end_alone);
    end
    if (end_alone) push_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic push_random(input int count);
    int len;
    for (int n = 0; n < count; ) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(80, 120) : $urandom_range(0, 35);
      push_message(len, 1'b1);
      n += len + 1;
    end
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_words.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    build_tables();
    restart_hash();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, extremes, block boundaries, idle and ignored bytes
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    for (int i = 0; i < 16; i++) push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h5a, 1'b0, 1'b1);
    drain();

    push_message(15, 1'b0);
    push_message(17, 1'b0);
    push_message(32, 1'b0);
    drain();

    push_random(150);
    drain();

    send_idle_pct = 55;
    push_random(100);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 55;
    hold_req = 1;
    push_random(100);
    drain();

    send_idle_pct = 31;
    recv_stall_pct = 31;
    push_random(100);
    drain();

    if (error_count == 0) begin
      $display("tb_aes_round_stream_hash_512: done, clean");
    end else begin
      $display("tb_aes_round_stream_hash_512: done, errors");
    end
    $finish;
  end

endmodule
